// ----- rtl/core/typeb_card_anticollision_assert.svh -----
// ----------------------------------------------------------------------------
// Type B card anticollision: assertion macros
// Concurrent checks clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TYPEB_CARD_ANTICOLLISION_ASSERT_SVH
`define TYPEB_CARD_ANTICOLLISION_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TBAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define TBAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TBAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TBAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/core/tbac_pkg.sv -----
// ----------------------------------------------------------------------------
// Type B card anticollision: shared package
// Field widths, command and phase codes, LFSR step and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tbac_pkg;

  localparam int unsigned SLOT_LIMIT_DEF = 16;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned FAM_W    = 8;
  localparam int unsigned SEED_W   = 16;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IX_W = 2;

  // divider takes this many dividend bits per cycle
  localparam int unsigned DIV_DIGIT  = 4;
  localparam int unsigned DIV_STEPS  = SEED_W / DIV_DIGIT;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [ID_W-1:0]   CARD_ID_RST = 32'd123;
  localparam logic [FAM_W-1:0]  FAMILY_RST  = 8'd2;
  localparam logic [SEED_W-1:0] SEED_RST    = 16'd44257;
  localparam logic [SEED_W-1:0] LFSR_MASK   = 16'hB400;

  localparam logic [CFG_IX_W-1:0] REG_CARD_ID     = 2'd0;
  localparam logic [CFG_IX_W-1:0] REG_CARD_FAMILY = 2'd1;
  localparam logic [CFG_IX_W-1:0] REG_RANDOM_SEED = 2'd2;

  localparam logic [OP_W-1:0] OP_REQB   = 3'd0;
  localparam logic [OP_W-1:0] OP_WUPB   = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd2;
  localparam logic [OP_W-1:0] OP_ATTRIB = 3'd3;
  localparam logic [OP_W-1:0] OP_HLTB   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ATQB   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ATTRIB = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HLTB   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_MARKER = 2'd1,
    PH_SELECT = 2'd2,
    PH_HALT   = 2'd3
  } phase_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic draw;
    logic div_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic has_result;
    logic out_free;
  } stat_t;

  // galois step, zero state replaced by one
  function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] s;
    s = (v == '0) ? SEED_W'(1) : v;
    if (s[0]) begin
      return (s >> 1) ^ LFSR_MASK;
    end
    return s >> 1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/typeb_card_anticollision.sv -----
// ----------------------------------------------------------------------------
// Type B card anticollision, card side: one reader command per transfer
// Result: registered at commit, after evaluation and, when a slot is drawn, division.
// One command at a time: input stalls until commit; a draw runs the radix-16 divider.
// Reset: card id 123, family 2, LFSR 44257, phase idle; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module typeb_card_anticollision #(
  parameter int unsigned SLOT_LIMIT = tbac_pkg::SLOT_LIMIT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tbac_pkg::CFG_IX_W-1:0] cfg_index_i,
  input  wire logic [tbac_pkg::ID_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tbac_pkg::OP_W-1:0]     opcode_i,
  input  wire logic [tbac_pkg::FAM_W-1:0]    family_i,
  input  wire logic [tbac_pkg::CNT_W-1:0]    slot_count_i,
  input  wire logic [tbac_pkg::CNT_W-1:0]    slot_number_i,
  input  wire logic [tbac_pkg::CHAN_W-1:0]   channel_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tbac_pkg::KIND_W-1:0]        reply_kind_o,
  output logic [tbac_pkg::ID_W-1:0]          reply_id_o,
  output logic [tbac_pkg::CHAN_W-1:0]        assigned_channel_o,
  output logic [1:0]                         phase_after_o
);
  import tbac_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tbac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tbac_dp #(
    .SLOT_LIMIT (SLOT_LIMIT)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .opcode_i           (opcode_i),
    .family_i           (family_i),
    .slot_count_i       (slot_count_i),
    .slot_number_i      (slot_number_i),
    .channel_id_i       (channel_id_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .reply_kind_o       (reply_kind_o),
    .reply_id_o         (reply_id_o),
    .assigned_channel_o (assigned_channel_o),
    .phase_after_o      (phase_after_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/tbac_ctrl.sv -----
// ----------------------------------------------------------------------------
// Type B card anticollision: controller
// Sequences capture, slot draw, division and commit of one reader command.
// ----------------------------------------------------------------------------
`default_nettype none
`include "typeb_card_anticollision_assert.svh"

module tbac_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire tbac_pkg::stat_t stat_i,
  output tbac_pkg::cmd_t      cmd_o
);
  import tbac_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.need_div) begin
          cmd_o.draw = 1'b1;
          state_d    = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold while an earlier result still waits for its transfer
        if (!stat_i.has_result || stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `TBAC_ASSERT_NXT(a_capture_eval, clk_i, rst_ni, cmd_o.capture, state_q == ST_EVAL, "capture did not lead to evaluation")
  `TBAC_ASSERT_NXT(a_div_done, clk_i, rst_ni, state_q == ST_DIV && stat_i.div_last, state_q == ST_EMIT, "division end missed")
  `TBAC_ASSERT_IMP(a_commit_free, clk_i, rst_ni, cmd_o.commit && stat_i.has_result, stat_i.out_free, "result committed over a held result")

endmodule

`default_nettype wire

// ----- rtl/core/tbac_dp.sv -----
// ----------------------------------------------------------------------------
// Type B card anticollision: datapath
// Config registers, command capture, LFSR, radix-16 slot divider, card phase
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "typeb_card_anticollision_assert.svh"

module tbac_dp #(
  parameter int unsigned SLOT_LIMIT = tbac_pkg::SLOT_LIMIT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tbac_pkg::cmd_t                cmd_i,
  output tbac_pkg::stat_t                    stat_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tbac_pkg::CFG_IX_W-1:0] cfg_index_i,
  input  wire logic [tbac_pkg::ID_W-1:0]     cfg_data_i,
  input  wire logic [tbac_pkg::OP_W-1:0]     opcode_i,
  input  wire logic [tbac_pkg::FAM_W-1:0]    family_i,
  input  wire logic [tbac_pkg::CNT_W-1:0]    slot_count_i,
  input  wire logic [tbac_pkg::CNT_W-1:0]    slot_number_i,
  input  wire logic [tbac_pkg::CHAN_W-1:0]   channel_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tbac_pkg::KIND_W-1:0]        reply_kind_o,
  output logic [tbac_pkg::ID_W-1:0]          reply_id_o,
  output logic [tbac_pkg::CHAN_W-1:0]        assigned_channel_o,
  output logic [1:0]                         phase_after_o
);
  import tbac_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(SLOT_LIMIT);

  logic [ID_W-1:0]   card_id_q;
  logic [FAM_W-1:0]  card_family_q;
  logic [SEED_W-1:0] lfsr_q;

  logic [OP_W-1:0]   op_q;
  logic [FAM_W-1:0]  fam_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  num_q;
  logic [CHAN_W-1:0] cid_q;
  logic [CNT_W-1:0]  cnt_sat;

  logic [SEED_W-1:0]    div_sh_q;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] chosen_slot_q, chosen_slot_d;

  logic              out_valid_q;
  logic [KIND_W-1:0] reply_kind_q, reply_kind_d;
  logic [ID_W-1:0]   reply_id_q, reply_id_d;
  logic [CHAN_W-1:0] chan_q, chan_d;
  phase_e            phase_after_q;

  logic             request, req_ok, multi, has_result;
  logic [CNT_W-1:0] draw_slot;

  // zero and oversized slot counts are folded at capture
  always_comb begin
    cnt_sat = slot_count_i;
    if (slot_count_i == '0) begin
      cnt_sat = CNT_W'(1);
    end else if (slot_count_i > LIMIT) begin
      cnt_sat = LIMIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      fam_q <= family_i;
      cnt_q <= cnt_sat;
      num_q <= slot_number_i;
      cid_q <= channel_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_id_q     <= CARD_ID_RST;
      card_family_q <= FAMILY_RST;
      lfsr_q        <= SEED_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_CARD_ID:     card_id_q     <= cfg_data_i;
          REG_CARD_FAMILY: card_family_q <= cfg_data_i[FAM_W-1:0];
          REG_RANDOM_SEED: lfsr_q        <= cfg_data_i[SEED_W-1:0];
          default: ;
        endcase
      end else if (cmd_i.draw) begin
        lfsr_q <= lfsr_next(lfsr_q);
      end
    end
  end

  // restoring remainder, one hex digit of the dividend per cycle
  always_comb begin
    logic [CNT_W:0] t;
    logic [CNT_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      t = {r, div_sh_q[SEED_W-1-i]};
      if (t >= {1'b0, cnt_q}) begin
        t = t - {1'b0, cnt_q};
      end
      r = t[CNT_W-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw) begin
      div_sh_q  <= lfsr_next(lfsr_q);
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_sh_q  <= div_sh_q << DIV_DIGIT;
      rem_q     <= rem_d;
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  assign request = ((phase_q == PH_IDLE) && (op_q == OP_REQB || op_q == OP_WUPB)) ||
                   ((phase_q == PH_HALT) && (op_q == OP_WUPB));
  assign req_ok    = request && (fam_q == '0 || fam_q == card_family_q);
  assign multi     = (cnt_q != CNT_W'(1));
  assign draw_slot = multi ? rem_q + CNT_W'(1) : CNT_W'(1);

  always_comb begin
    phase_d       = phase_q;
    chosen_slot_d = chosen_slot_q;
    has_result    = 1'b0;
    reply_kind_d  = KIND_ATQB;
    reply_id_d    = '0;
    chan_d        = '0;
    unique case (phase_q)
      PH_IDLE, PH_HALT: begin
        if (req_ok) begin
          chosen_slot_d = draw_slot;
          if (draw_slot == CNT_W'(1)) begin
            phase_d    = PH_SELECT;
            has_result = 1'b1;
            reply_id_d = card_id_q;
          end else begin
            phase_d = PH_MARKER;
          end
        end
      end
      PH_MARKER: begin
        if (op_q == OP_MARK && num_q == chosen_slot_q) begin
          phase_d    = PH_SELECT;
          has_result = 1'b1;
          reply_id_d = card_id_q;
        end
      end
      PH_SELECT: begin
        if (op_q == OP_ATTRIB) begin
          phase_d      = PH_HALT;
          has_result   = 1'b1;
          reply_kind_d = KIND_ATTRIB;
          chan_d       = cid_q;
        end else if (op_q == OP_HLTB) begin
          phase_d      = PH_HALT;
          has_result   = 1'b1;
          reply_kind_d = KIND_HLTB;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      chosen_slot_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        phase_q       <= phase_d;
        chosen_slot_q <= chosen_slot_d;
      end
      if (cmd_i.commit && has_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && has_result) begin
      reply_kind_q  <= reply_kind_d;
      reply_id_q    <= reply_id_d;
      chan_q        <= chan_d;
      phase_after_q <= phase_d;
    end
  end

  assign stat_o.need_div   = req_ok && multi;
  assign stat_o.div_last   = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat_o.has_result = has_result;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign reply_kind_o       = reply_kind_q;
  assign reply_id_o         = reply_id_q;
  assign assigned_channel_o = chan_q;
  assign phase_after_o      = phase_after_q;

  `TBAC_ASSERT_IMP(a_slot_range, clk_i, rst_ni, 1'b1, chosen_slot_q <= LIMIT, "chosen slot beyond limit")
  `TBAC_ASSERT_NXT(a_lfsr_live, clk_i, rst_ni, cmd_i.draw && !cfg_we_i, lfsr_q != '0, "lfsr stepped into zero")
  `TBAC_ASSERT_NXT(a_rem_bound, clk_i, rst_ni, cmd_i.div_step, rem_q < cnt_q, "remainder not below slot count")
  `TBAC_ASSERT_NXT(a_atqb_select, clk_i, rst_ni, cmd_i.commit && has_result && reply_kind_d == KIND_ATQB, phase_q == PH_SELECT, "atqb without waiting for select")

endmodule

`default_nettype wire
